@@ rtl/core/dclw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dclw_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned ERR_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEIL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE    = 3'd4;

  // Reset values
  localparam logic [BYTE_W-1:0]  RST_TIMEOUT_TICKS = 8'd10;
  localparam logic [ERR_W-1:0]   RST_ERROR_LIMIT   = 16'd1000;
  localparam logic [LIMIT_W-1:0] RST_DUTY_MIN      = 9'd32;
  localparam logic [LIMIT_W-1:0] RST_DUTY_CEIL     = 9'd256;
  localparam logic [DUTY_W-1:0]  RST_FULL_SCALE    = 10'd511;
  localparam logic [DUTY_W-1:0]  RST_HELD_DUTY     = 10'd1023;

  // Saturation points and duty clip floor
  localparam logic [BYTE_W-1:0] TICK_SAT     = 8'd255;
  localparam logic [ERR_W-1:0]  BAD_SAT      = 16'd65535;
  localparam logic [DUTY_W-1:0] DUTY_CLIP_LO = 10'd1;

  typedef struct packed {
    logic [BYTE_W-1:0]  timeout_ticks;
    logic [ERR_W-1:0]   error_limit;
    logic [LIMIT_W-1:0] duty_min;
    logic [LIMIT_W-1:0] duty_ceil;
    logic [DUTY_W-1:0]  full_scale;
  } cfg_t;

  typedef struct packed {
    logic              frame_done;
    logic              frame_good;
    logic              drive_enable;
    logic [DUTY_W-1:0] low_side_duty;
    logic [DUTY_W-1:0] high_side_duty;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/dclw_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Input channel: one serial byte or one timer tick per transfer
interface dclw_in_if;
  import dclw_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

// Result channel: link status and held duty pair
interface dclw_out_if;
  import dclw_pkg::*;
  logic              valid;
  logic              ready;
  logic              frame_done;
  logic              frame_good;
  logic              drive_enable;
  logic [DUTY_W-1:0] low_side_duty;
  logic [DUTY_W-1:0] high_side_duty;

  modport source (output valid, frame_done, frame_good, drive_enable, low_side_duty,
                  high_side_duty, input ready);
  modport sink   (input valid, frame_done, frame_good, drive_enable, low_side_duty,
                  high_side_duty, output ready);
endinterface
`default_nettype wire

@@ rtl/core/dclw_duty.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Clips the commanded duty and forms the complementary pair
module dclw_duty (
  input  wire logic [dclw_pkg::BYTE_W-1:0] duty_byte,
  input  wire dclw_pkg::cfg_t              cfg,
  output logic [dclw_pkg::DUTY_W-1:0]      low_duty,
  output logic [dclw_pkg::DUTY_W-1:0]      high_duty
);
  import dclw_pkg::*;

  logic [LIMIT_W-1:0]      duty_ext;
  logic [LIMIT_W-1:0]      duty_clip;
  logic signed [DUTY_W:0]  low_diff;

  // Clip to [duty_min, duty_ceil]; min wins when limits cross below it
  always_comb begin
    duty_ext = {1'b0, duty_byte};
    if (duty_ext < cfg.duty_min) begin
      duty_clip = cfg.duty_min;
    end else if (duty_ext > cfg.duty_ceil) begin
      duty_clip = cfg.duty_ceil;
    end else begin
      duty_clip = duty_ext;
    end
  end

  // Low side is full_scale - duty, floored at one
  always_comb begin
    low_diff = $signed({1'b0, cfg.full_scale}) - $signed({2'b00, duty_clip});
    if (low_diff < $signed({1'b0, DUTY_CLIP_LO})) begin
      low_duty = DUTY_CLIP_LO;
    end else begin
      low_duty = low_diff[DUTY_W-1:0];
    end
  end

  // High side is the duty itself, floored at one
  assign high_duty = (duty_clip == '0) ? DUTY_CLIP_LO : {1'b0, duty_clip};

endmodule
`default_nettype wire

@@ rtl/core/dclw_link.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Frame receiver, partial frame timeout and link watchdog state
module dclw_link (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic                       mode,
  input  wire logic [dclw_pkg::BYTE_W-1:0] rx_byte,
  input  wire dclw_pkg::cfg_t             cfg,
  output dclw_pkg::result_t               result
);
  import dclw_pkg::*;

  logic              byte_pos_r, byte_pos_nxt;
  logic [BYTE_W-1:0] first_byte_r, first_byte_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              receiving_r, receiving_nxt;
  logic [BYTE_W-1:0] partial_ticks_r, partial_ticks_nxt;
  logic              link_good_r, link_good_nxt;
  logic [ERR_W-1:0]  bad_ticks_r, bad_ticks_nxt;
  logic              enabled_r, enabled_nxt;
  logic [DUTY_W-1:0] held_low_r, held_low_nxt;
  logic [DUTY_W-1:0] held_high_r, held_high_nxt;
  logic [DUTY_W-1:0] new_low;
  logic [DUTY_W-1:0] new_high;
  logic              done;
  logic              good;

  // Duty pair from the stored first byte
  dclw_duty u_duty (
    .duty_byte (first_byte_r),
    .cfg       (cfg),
    .low_duty  (new_low),
    .high_duty (new_high)
  );

  // Next state for one byte or one tick
  always_comb begin
    byte_pos_nxt      = byte_pos_r;
    first_byte_nxt    = first_byte_r;
    sum_nxt           = sum_r;
    receiving_nxt     = receiving_r;
    partial_ticks_nxt = partial_ticks_r;
    link_good_nxt     = link_good_r;
    bad_ticks_nxt     = bad_ticks_r;
    enabled_nxt       = enabled_r;
    held_low_nxt      = held_low_r;
    held_high_nxt     = held_high_r;
    done              = 1'b0;
    good              = 1'b0;

    if (mode == MODE_BYTE) begin
      receiving_nxt = 1'b1;
      if (!byte_pos_r) begin
        first_byte_nxt = rx_byte;
        sum_nxt        = sum_r + rx_byte;
        byte_pos_nxt   = 1'b1;
      end else begin
        // Checksum byte closes the frame
        done              = 1'b1;
        good              = (sum_r == rx_byte);
        byte_pos_nxt      = 1'b0;
        receiving_nxt     = 1'b0;
        partial_ticks_nxt = '0;
        sum_nxt           = '0;
        link_good_nxt     = good;
        if (good) begin
          held_low_nxt  = new_low;
          held_high_nxt = new_high;
          enabled_nxt   = 1'b1;
        end
      end
    end else begin
      // Timeout first; the watchdog then sees the link state it leaves
      if (receiving_r) begin
        if (partial_ticks_r != TICK_SAT) begin
          partial_ticks_nxt = partial_ticks_r + 1'b1;
        end
        if (partial_ticks_nxt > cfg.timeout_ticks) begin
          byte_pos_nxt      = 1'b0;
          sum_nxt           = '0;
          receiving_nxt     = 1'b0;
          partial_ticks_nxt = '0;
          link_good_nxt     = 1'b0;
        end
      end
      if (!link_good_nxt) begin
        if (bad_ticks_r != BAD_SAT) begin
          bad_ticks_nxt = bad_ticks_r + 1'b1;
        end
        if (bad_ticks_nxt > cfg.error_limit) begin
          enabled_nxt = 1'b0;
        end
      end else begin
        bad_ticks_nxt = '0;
      end
    end
  end

  assign result.frame_done     = done;
  assign result.frame_good     = good;
  assign result.drive_enable   = enabled_nxt;
  assign result.low_side_duty  = held_low_nxt;
  assign result.high_side_duty = held_high_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r      <= 1'b0;
      first_byte_r    <= '0;
      sum_r           <= '0;
      receiving_r     <= 1'b0;
      partial_ticks_r <= '0;
      link_good_r     <= 1'b0;
      bad_ticks_r     <= '0;
      enabled_r       <= 1'b0;
      held_low_r      <= RST_HELD_DUTY;
      held_high_r     <= RST_HELD_DUTY;
    end else if (step) begin
      byte_pos_r      <= byte_pos_nxt;
      first_byte_r    <= first_byte_nxt;
      sum_r           <= sum_nxt;
      receiving_r     <= receiving_nxt;
      partial_ticks_r <= partial_ticks_nxt;
      link_good_r     <= link_good_nxt;
      bad_ticks_r     <= bad_ticks_nxt;
      enabled_r       <= enabled_nxt;
      held_low_r      <= held_low_nxt;
      held_high_r     <= held_high_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/duty_command_link_watchdog_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Command link watchdog for a complementary half-bridge. Each input transfer is a
// serial byte or a timer tick and gives exactly one result transfer. An item passes
// an input register, the frame/watchdog logic and the result register, and one item
// is taken every cycle while results drain; while a result waits, one more input
// transfer is taken into the free input register, after which the input stalls
// until the result drains. Frames are a duty byte and a mod-256 checksum byte;
// registers are written through cfg_* and take effect on the next item.
module duty_command_link_watchdog_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  dclw_in_if.sink                                  in_ch,
  dclw_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [dclw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dclw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dclw_pkg::*;

  cfg_t              cfg_r;
  logic              in_valid_r;
  logic              in_mode_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           result;
  logic              step;

  // Stage advance: the input register holds an item and the result register is empty or being drained
  assign step         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= RST_TIMEOUT_TICKS;
      cfg_r.error_limit   <= RST_ERROR_LIMIT;
      cfg_r.duty_min      <= RST_DUTY_MIN;
      cfg_r.duty_ceil     <= RST_DUTY_CEIL;
      cfg_r.full_scale    <= RST_FULL_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data[BYTE_W-1:0];
        CFG_ERROR_LIMIT:   cfg_r.error_limit   <= cfg_data[ERR_W-1:0];
        CFG_DUTY_MIN:      cfg_r.duty_min      <= cfg_data[LIMIT_W-1:0];
        CFG_DUTY_CEIL:     cfg_r.duty_ceil     <= cfg_data[LIMIT_W-1:0];
        CFG_FULL_SCALE:    cfg_r.full_scale    <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_mode_r <= in_ch.mode;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  dclw_link u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .mode    (in_mode_r),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_done     = out_r.frame_done;
  assign out_ch.frame_good     = out_r.frame_good;
  assign out_ch.drive_enable   = out_r.drive_enable;
  assign out_ch.low_side_duty  = out_r.low_side_duty;
  assign out_ch.high_side_duty = out_r.high_side_duty;

endmodule
`default_nettype wire

@@ rtl/core/dclw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the result channel
module dclw_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          frame_done,
  input wire logic                          frame_good,
  input wire logic                          drive_enable,
  input wire logic [dclw_pkg::DUTY_W-1:0]   low_side_duty,
  input wire logic [dclw_pkg::DUTY_W-1:0]   high_side_duty
);
  import dclw_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A good frame is a completed frame and turns the drive on
  a_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_good |-> frame_done && drive_enable)
    else $error("good frame without done or enable");

  // Duties never fall to zero
  a_duty_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> low_side_duty != '0 && high_side_duty != '0)
    else $error("duty below clip floor");

endmodule

bind duty_command_link_watchdog_top dclw_checker u_dclw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .frame_done     (out_ch.frame_done),
  .frame_good     (out_ch.frame_good),
  .drive_enable   (out_ch.drive_enable),
  .low_side_duty  (out_ch.low_side_duty),
  .high_side_duty (out_ch.high_side_duty)
);
`default_nettype wire

@@ bench/dclw_link_checker.sv @@
`timescale 1ns / 1ps
// Watches the byte/tick channel, the result channel and the register port.
// Keeps its own copy of the frame receiver and watchdog, predicts one status
// per accepted input transfer and compares it with the result transfers in order.
module dclw_link_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dclw_in_if                                   mon_in,
  dclw_out_if                                  mon_out,
  input  wire logic                            cfg_we,
  input  wire logic [dclw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dclw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   error_total,
  output int                                   outstanding
);
  import dclw_pkg::*;

  localparam int DUTY_CLIP_HI = 1023;

  // Register mirror
  cfg_t link_cfg;

  // Receiver and watchdog state
  logic              second_byte;
  logic [BYTE_W-1:0] duty_byte;
  logic [BYTE_W-1:0] checksum_acc;
  logic              in_frame;
  logic [BYTE_W-1:0] frame_ticks;
  logic              link_ok;
  logic [ERR_W-1:0]  bad_tick_cnt;
  logic              drive_on;
  logic [DUTY_W-1:0] low_duty;
  logic [DUTY_W-1:0] high_duty;

  // Expected status, oldest first
  result_t expected_status[$];

  function automatic logic [DUTY_W-1:0] clamp_duty(input int v);
    if (v < int'(DUTY_CLIP_LO)) return DUTY_CLIP_LO;
    if (v > DUTY_CLIP_HI) return DUTY_W'(DUTY_CLIP_HI);
    return DUTY_W'(v);
  endfunction

  // One byte or tick through the receiver and the watchdog
  function automatic result_t advance_link(input logic kind, input logic [BYTE_W-1:0] rx);
    result_t            r;
    logic [LIMIT_W-1:0] duty;
    r = '0;
    if (kind == MODE_BYTE) begin
      in_frame = 1'b1;
      if (!second_byte) begin
        duty_byte    = rx;
        checksum_acc = checksum_acc + rx;
        second_byte  = 1'b1;
      end else begin
        r.frame_done = 1'b1;
        r.frame_good = (checksum_acc == rx);
        second_byte  = 1'b0;
        in_frame     = 1'b0;
        frame_ticks  = '0;
        checksum_acc = '0;
        link_ok      = r.frame_good;
        if (r.frame_good) begin
          // clip; crossed limits resolve toward duty_min only below it
          duty = {1'b0, duty_byte};
          if (duty < link_cfg.duty_min) duty = link_cfg.duty_min;
          else if (duty > link_cfg.duty_ceil) duty = link_cfg.duty_ceil;
          low_duty  = clamp_duty(int'(link_cfg.full_scale) - int'(duty));
          high_duty = clamp_duty(int'(duty));
          drive_on  = 1'b1;
        end
      end
    end else begin
      // partial frame timeout first
      if (in_frame) begin
        if (frame_ticks != TICK_SAT) frame_ticks = frame_ticks + 1'b1;
        if (frame_ticks > link_cfg.timeout_ticks) begin
          second_byte  = 1'b0;
          checksum_acc = '0;
          in_frame     = 1'b0;
          frame_ticks  = '0;
          link_ok      = 1'b0;
        end
      end
      // then the bad tick count
      if (!link_ok) begin
        if (bad_tick_cnt != BAD_SAT) bad_tick_cnt = bad_tick_cnt + 1'b1;
        if (bad_tick_cnt > link_cfg.error_limit) drive_on = 1'b0;
      end else begin
        bad_tick_cnt = '0;
      end
    end
    r.drive_enable   = drive_on;
    r.low_side_duty  = low_duty;
    r.high_side_duty = high_duty;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [DUTY_W-1:0] want,
                             input logic [DUTY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_total++;
    end
  endtask

  // Sample both channels and the register port at each edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      link_cfg.timeout_ticks = RST_TIMEOUT_TICKS;
      link_cfg.error_limit   = RST_ERROR_LIMIT;
      link_cfg.duty_min      = RST_DUTY_MIN;
      link_cfg.duty_ceil     = RST_DUTY_CEIL;
      link_cfg.full_scale    = RST_FULL_SCALE;
      second_byte  = 1'b0;
      duty_byte    = '0;
      checksum_acc = '0;
      in_frame     = 1'b0;
      frame_ticks  = '0;
      link_ok      = 1'b0;
      bad_tick_cnt = '0;
      drive_on     = 1'b0;
      low_duty     = RST_HELD_DUTY;
      high_duty    = RST_HELD_DUTY;
      expected_status.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT_TICKS: link_cfg.timeout_ticks = cfg_data[BYTE_W-1:0];
          CFG_ERROR_LIMIT:   link_cfg.error_limit   = cfg_data[ERR_W-1:0];
          CFG_DUTY_MIN:      link_cfg.duty_min      = cfg_data[LIMIT_W-1:0];
          CFG_DUTY_CEIL:     link_cfg.duty_ceil     = cfg_data[LIMIT_W-1:0];
          CFG_FULL_SCALE:    link_cfg.full_scale    = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end

      // result transfer against the oldest expectation
      if (mon_out.valid && mon_out.ready) begin
        got.frame_done     = mon_out.frame_done;
        got.frame_good     = mon_out.frame_good;
        got.drive_enable   = mon_out.drive_enable;
        got.low_side_duty  = mon_out.low_side_duty;
        got.high_side_duty = mon_out.high_side_duty;
        if (expected_status.size() == 0) begin
          $error("result transfer with no expected status pending");
          error_total++;
        end else begin
          want = expected_status.pop_front();
          check_field("frame_done", DUTY_W'(want.frame_done), DUTY_W'(got.frame_done));
          check_field("frame_good", DUTY_W'(want.frame_good), DUTY_W'(got.frame_good));
          check_field("drive_enable", DUTY_W'(want.drive_enable),
                      DUTY_W'(got.drive_enable));
          check_field("low_side_duty", want.low_side_duty, got.low_side_duty);
          check_field("high_side_duty", want.high_side_duty, got.high_side_duty);
        end
      end

      // input transfer: predict its status
      if (mon_in.valid && mon_in.ready)
        expected_status.push_back(advance_link(mon_in.mode, mon_in.rx_byte));
    end
    outstanding <= expected_status.size();
  end

endmodule

@@ bench/duty_command_link_watchdog_top_tb.sv @@
`timescale 1ns / 1ps
// Drives command frames and timer ticks into the link watchdog, changes the
// limits between phases and gives the verdict from the checker's error count.
module duty_command_link_watchdog_top_tb;
  import dclw_pkg::*;

  localparam int RESET_CYCLES     = 7;
  localparam int STALL_LIMIT      = 1000;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int PHASES           = 8;
  localparam int RANDOM_ITEMS     = 640;
  localparam int SAT_TICK_RUN     = 260;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dclw_in_if  in_ch ();
  dclw_out_if out_ch ();

  int error_total;
  int outstanding;

  // calm is read by sender and receiver, long_hold_req by the receiver; the rest is sender state
  bit calm;
  bit long_hold_req;
  int items_sent;
  int tx_stall_pct;

  duty_command_link_watchdog_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dclw_link_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .mon_in      (in_ch),
    .mon_out     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_total (error_total),
    .outstanding (outstanding)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One input transfer, with an occasional short gap ahead of it
  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] data);
    int gap;
    if (items_sent % 40 == 0) tx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
    items_sent++;
    if (!calm && $urandom_range(0, 99) < tx_stall_pct) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= kind;
    in_ch.rx_byte <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] duty, input logic [BYTE_W-1:0] sum);
    send_item(MODE_BYTE, duty);
    send_item(MODE_BYTE, sum);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(MODE_TICK, 8'($urandom));
  endtask

  // Stop offering and let every expected status come out
  task automatic drain_link();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Limits for one phase; extremes in phases 1 and 2
  task automatic program_phase(input int phase);
    logic [CFG_DATA_W-1:0] tmo, elim, dmin, dceil, fscale;
    case (phase)
      0: begin
        tmo    = 16'($urandom_range(1, 12));
        elim   = 16'($urandom_range(5, 40));
        dmin   = 16'($urandom_range(0, 100));
        dceil  = 16'($urandom_range(150, 511));
        fscale = 16'($urandom_range(200, 1023));
      end
      1: begin
        tmo = '0; elim = '0; dmin = '0; dceil = 16'd511; fscale = '0;
      end
      2: begin
        tmo = 16'd255; elim = 16'hFFFF; dmin = 16'd511; dceil = '0; fscale = 16'd1023;
      end
      3: begin
        // crossed limits
        tmo    = 16'($urandom_range(0, 5));
        elim   = 16'($urandom_range(0, 10));
        dmin   = 16'($urandom_range(256, 511));
        dceil  = 16'($urandom_range(0, 255));
        fscale = 16'($urandom_range(0, 1023));
      end
      4: begin
        tmo    = CFG_DATA_W'(RST_TIMEOUT_TICKS);
        elim   = CFG_DATA_W'(RST_ERROR_LIMIT);
        dmin   = CFG_DATA_W'(RST_DUTY_MIN);
        dceil  = CFG_DATA_W'(RST_DUTY_CEIL);
        fscale = CFG_DATA_W'(RST_FULL_SCALE);
      end
      5: begin
        tmo    = 16'($urandom_range(0, 30));
        elim   = 16'($urandom_range(0, 60));
        dmin   = 16'($urandom_range(0, 511));
        dceil  = 16'($urandom_range(0, 511));
        fscale = 16'($urandom_range(0, 1023));
      end
      default: begin
        // full-width words; bits above each register are dropped
        tmo    = 16'($urandom);
        elim   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 60)) : 16'($urandom);
        dmin   = 16'($urandom);
        dceil  = 16'($urandom);
        fscale = 16'($urandom);
      end
    endcase
    cfg_write(CFG_TIMEOUT_TICKS, tmo);
    cfg_write(CFG_ERROR_LIMIT, elim);
    cfg_write(CFG_DUTY_MIN, dmin);
    cfg_write(CFG_DUTY_CEIL, dceil);
    cfg_write(CFG_FULL_SCALE, fscale);
    cfg_we <= 1'b0;
  endtask

  // Well-formed frames half the time, plus bad checksums, partial frames and tick runs
  task automatic random_burst(output int count);
    int                pick;
    int                ticks;
    logic [BYTE_W-1:0] duty;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0:       duty = '0;
      1:       duty = '1;
      default: duty = 8'($urandom);
    endcase
    count = 0;
    ticks = 0;
    if (pick < 50) begin
      // checksum equals the duty byte when frames are aligned
      send_frame(duty, duty);
      count = 2;
      ticks = $urandom_range(0, 2);
    end else if (pick < 62) begin
      send_frame(duty, duty ^ 8'($urandom_range(1, 255)));
      count = 2;
    end else if (pick < 80) begin
      send_item(MODE_BYTE, duty);
      count = 1;
      ticks = $urandom_range(1, 14);
    end else if (pick < 95) begin
      ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      send_item(MODE_BYTE, duty);
      count = 1;
    end
    send_ticks(ticks);
    count += ticks;
    // late checksum for a partial frame, which may have timed out
    if (pick >= 62 && pick < 80 && $urandom_range(0, 1) == 1) begin
      send_item(MODE_BYTE, duty);
      count++;
    end
  endtask

  // Stimulus and verdict
  initial begin
    int phase;
    int sent;
    int chunk;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_TIMEOUT_TICKS;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_TICK;
    in_ch.rx_byte <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset limits
    send_item(MODE_TICK, 8'h00);             // bad tick before any frame
    send_frame(8'h00, 8'h00);                // duty below min
    send_item(MODE_TICK, 8'hFF);             // good link clears bad ticks
    send_frame(8'hFF, 8'hFF);                // largest duty byte, still inside the reset limits
    send_frame(8'h05, 8'h06);                // bad checksum
    send_frame(8'd100, 8'd100);
    send_item(MODE_BYTE, 8'd77);             // partial frame, then time it out
    send_ticks(int'(RST_TIMEOUT_TICKS) + 1);
    send_frame(8'd40, 8'd40);

    // Random phases
    for (phase = 0; phase < PHASES; phase++) begin
      drain_link();
      program_phase(phase);
      if (phase == 1) long_hold_req = 1'b1;
      if (phase == PHASES - 1) calm = 1'b1;
      if (phase == 2) begin
        // frame tick count saturates without timing out
        send_item(MODE_BYTE, 8'd123);
        send_ticks(SAT_TICK_RUN);
        send_item(MODE_BYTE, 8'd123);
      end
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        random_burst(chunk);
        sent += chunk;
      end
    end

    drain_link();
    if (error_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: short random stalls, one long hold-off
  initial begin
    int span;
    int stall_pct;
    int gap;
    bit hold_done;
    span      = 0;
    stall_pct = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (span == 0) begin
        span      = 50;
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      end
      span--;
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        gap = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any transfer
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
